@@ hdl/sfa_pkg.sv @@
// Package for the slot free-list allocator: sizes, codes and payload types.
package sfa_pkg;

   localparam int SLOT_CAPACITY = 1024;
   localparam int SLOT_W        = $clog2(SLOT_CAPACITY);
   localparam int COUNT_W       = $clog2(SLOT_CAPACITY + 1);

   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_FULL        = 2'd1,
      ST_BAD_RELEASE = 2'd2
   } status_type;

   typedef enum logic {
      FSM_IDLE,
      FSM_EXEC
   } fsm_type;

   typedef struct packed {
      logic        opcode;
      logic [9:0]  slot_in;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [9:0]  slot_out;
      logic [10:0] high_water;
   } rsp_type;

   typedef struct packed {
      logic              stack_rd_en;
      logic [SLOT_W-1:0] stack_rd_addr;
      logic              stack_wr_en;
      logic [SLOT_W-1:0] stack_wr_addr;
      logic [SLOT_W-1:0] stack_wr_data;
      logic              mark_rd_en;
      logic [SLOT_W-1:0] mark_rd_addr;
      logic              mark_wr_en;
      logic [SLOT_W-1:0] mark_wr_addr;
      logic              mark_wr_data;
   } mem_cmd_type;

endpackage

@@ hdl/slot_free_list_allocator.sv @@
// Top level of the slot free-list allocator.
//
//   channel   ports                              direction
//   request   req_valid, req_stall, req_data     in  (opcode, slot_in)
//   result    rsp_valid, rsp_stall, rsp_data     out (status, slot_out, high_water)
//
// A request is accepted in FSM_IDLE, which reads the stack top and the slot's in-use
// mark; FSM_EXEC updates the mark, and on a release the stack, unless the request fails,
// and loads the result register; no new request is accepted before that load.
// Reset clears the counters and control only; marks at or above the high-water count
// are ignored by the release check, so the mark memory needs no clearing pass.
// A result waiting under rsp_stall does not block the next request's accept; that
// request then waits in FSM_EXEC until the result register drains.
module slot_free_list_allocator (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sfa_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sfa_pkg::rsp_type  rsp_data
);

   sfa_pkg::mem_cmd_type        mem_cmd;
   logic [sfa_pkg::SLOT_W-1:0]  stack_rd_data;
   logic [0:0]                  mark_rd_data;

   sfa_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .mem_cmd       (mem_cmd),
      .stack_rd_data (stack_rd_data),
      .mark_rd_data  (mark_rd_data[0])
   );

   sfa_ram #(
      .DEPTH (sfa_pkg::SLOT_CAPACITY),
      .WIDTH (sfa_pkg::SLOT_W)
   ) u_stack (
      .clock   (clock),
      .wr_en   (mem_cmd.stack_wr_en),
      .wr_addr (mem_cmd.stack_wr_addr),
      .wr_data (mem_cmd.stack_wr_data),
      .rd_en   (mem_cmd.stack_rd_en),
      .rd_addr (mem_cmd.stack_rd_addr),
      .rd_data (stack_rd_data)
   );

   sfa_ram #(
      .DEPTH (sfa_pkg::SLOT_CAPACITY),
      .WIDTH (1)
   ) u_mark (
      .clock   (clock),
      .wr_en   (mem_cmd.mark_wr_en),
      .wr_addr (mem_cmd.mark_wr_addr),
      .wr_data (mem_cmd.mark_wr_data),
      .rd_en   (mem_cmd.mark_rd_en),
      .rd_addr (mem_cmd.mark_rd_addr),
      .rd_data (mark_rd_data)
   );

endmodule

@@ hdl/sfa_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module sfa_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 10
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/sfa_ctrl.sv @@
// Allocator sequencer: counters, read-modify-write of stack and marks, result register.
module sfa_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  sfa_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output sfa_pkg::rsp_type            rsp_data,
   output sfa_pkg::mem_cmd_type        mem_cmd,
   input  logic [sfa_pkg::SLOT_W-1:0]  stack_rd_data,
   input  logic                        mark_rd_data
);

   sfa_pkg::fsm_type                 state_ff, state_in;
   logic                             op_ff, op_in;
   logic [sfa_pkg::SLOT_W-1:0]       slot_ff, slot_in;
   logic [sfa_pkg::COUNT_W-1:0]      free_depth_ff, free_depth_in;
   logic [sfa_pkg::COUNT_W-1:0]      used_count_ff, used_count_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   sfa_pkg::rsp_type                 rsp_data_ff, rsp_data_in;

   logic                             accept;
   logic                             go;
   logic                             bad;
   logic [sfa_pkg::COUNT_W-1:0]      slot_ext;
   logic [sfa_pkg::COUNT_W-1:0]      grant_ext;
   logic [sfa_pkg::SLOT_W-1:0]       grant;
   sfa_pkg::status_type              status;
   logic [sfa_pkg::SLOT_W-1:0]       slot_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sfa_pkg::FSM_IDLE;
         free_depth_ff <= '0;
         used_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_depth_ff <= free_depth_in;
         used_count_ff <= used_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      slot_ff     <= slot_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != sfa_pkg::FSM_IDLE);
   assign accept    = req_valid & ~req_stall;
   assign go        = ~rsp_valid_ff | ~rsp_stall;
   assign slot_ext  = sfa_pkg::COUNT_W'(slot_ff);
   assign grant_ext = sfa_pkg::COUNT_W'(grant);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      slot_in       = slot_ff;
      free_depth_in = free_depth_ff;
      used_count_in = used_count_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_data_in   = rsp_data_ff;
      bad           = 1'b0;
      grant         = '0;
      status        = sfa_pkg::ST_OK;
      slot_res      = '0;

      mem_cmd               = '0;
      mem_cmd.stack_rd_en   = accept;
      mem_cmd.stack_rd_addr = sfa_pkg::SLOT_W'(free_depth_ff - 1'b1);
      mem_cmd.mark_rd_en    = accept;
      mem_cmd.mark_rd_addr  = sfa_pkg::SLOT_W'(req_data.slot_in);

      case (state_ff)
         sfa_pkg::FSM_IDLE: begin
            if (accept) begin
               op_in    = req_data.opcode;
               slot_in  = sfa_pkg::SLOT_W'(req_data.slot_in);
               state_in = sfa_pkg::FSM_EXEC;
            end
         end
         sfa_pkg::FSM_EXEC: begin
            if (op_ff == sfa_pkg::OP_ALLOC) begin
               if (free_depth_ff != '0) begin
                  grant                = stack_rd_data;
                  slot_res             = grant;
                  free_depth_in        = free_depth_ff - 1'b1;
                  mem_cmd.mark_wr_en   = go & (grant_ext < sfa_pkg::COUNT_W'(sfa_pkg::SLOT_CAPACITY));
                  mem_cmd.mark_wr_addr = grant;
                  mem_cmd.mark_wr_data = 1'b1;
               end else if (used_count_ff >= sfa_pkg::COUNT_W'(sfa_pkg::SLOT_CAPACITY)) begin
                  status = sfa_pkg::ST_FULL;
               end else begin
                  grant                = sfa_pkg::SLOT_W'(used_count_ff);
                  slot_res             = grant;
                  used_count_in        = used_count_ff + 1'b1;
                  mem_cmd.mark_wr_en   = go;
                  mem_cmd.mark_wr_addr = grant;
                  mem_cmd.mark_wr_data = 1'b1;
               end
            end else begin
               slot_res = slot_ff;
               bad = (slot_ext >= used_count_ff)
                  || (slot_ext >= sfa_pkg::COUNT_W'(sfa_pkg::SLOT_CAPACITY))
                  || !mark_rd_data
                  || (free_depth_ff >= sfa_pkg::COUNT_W'(sfa_pkg::SLOT_CAPACITY));
               if (bad) begin
                  status = sfa_pkg::ST_BAD_RELEASE;
               end else begin
                  free_depth_in         = free_depth_ff + 1'b1;
                  mem_cmd.mark_wr_en    = go;
                  mem_cmd.mark_wr_addr  = slot_ff;
                  mem_cmd.mark_wr_data  = 1'b0;
                  mem_cmd.stack_wr_en   = go;
                  mem_cmd.stack_wr_addr = sfa_pkg::SLOT_W'(free_depth_ff);
                  mem_cmd.stack_wr_data = slot_ff;
               end
            end
            if (go) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.status     = status;
               rsp_data_in.slot_out   = 10'(slot_res);
               rsp_data_in.high_water = 11'(used_count_in);
               state_in               = sfa_pkg::FSM_IDLE;
            end else begin
               free_depth_in = free_depth_ff;
               used_count_in = used_count_ff;
            end
         end
         default: begin
            state_in = sfa_pkg::FSM_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ hdl/sfa_checker.sv @@
// Port-level checker for the slot free-list allocator, bound to the top level.
module sfa_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input sfa_pkg::rsp_type  rsp_data
);

   // held result must not change
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // one request in flight: stall follows every accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while another was in flight");

   a_full_at_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == sfa_pkg::ST_FULL |->
         rsp_data.high_water == 11'(sfa_pkg::SLOT_CAPACITY) && rsp_data.slot_out == 10'd0)
      else $error("full status below capacity or with non-zero slot");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("state not cleared by reset");

endmodule

bind slot_free_list_allocator sfa_checker u_sfa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
